### rtl/core/tts_pkg.sv
// tts_pkg: shared types and codes for the tlv tag scanner
// holds the input item and result structs, scan phase and status codes
// no dependencies
`timescale 1ns / 1ps

package tts_pkg;

    // scan phase codes
    localparam logic [1:0] PHASE_TAG = 2'd0;
    localparam logic [1:0] PHASE_LEN = 2'd1;
    localparam logic [1:0] PHASE_VAL = 2'd2;

    // search status codes
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_ABSENT  = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;

    // one frame byte with its side fields
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] frame_length;
        logic [7:0]  wanted_tag;
    } item_t;

    // one search result
    typedef struct packed {
        logic [1:0]  search_status;
        logic [15:0] value_offset;
        logic [7:0]  value_length;
    } result_t;

endpackage

### rtl/core/tts_in_stage.sv
// tts_in_stage: input register of the tlv tag scanner
// holds one byte transaction until the scan step takes it
// depends on tts_pkg
`timescale 1ns / 1ps

module tts_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tts_pkg::item_t in_item,
    input  logic           take,
    output logic           item_valid,
    output tts_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    tts_pkg::item_t item_reg;

    // room when empty or when the held item moves on this cycle
    assign in_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/core/tts_scan_core.sv
// tts_scan_core: record walker and decision logic of the tlv tag scanner
// keeps the scan state and decides found, absent or overrun per byte
// depends on tts_pkg
`timescale 1ns / 1ps

module tts_scan_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  tts_pkg::item_t   item,
    output logic             emit,
    output tts_pkg::result_t result
);

    logic [1:0]  phase_reg,  phase_next;
    logic [15:0] pos_reg,    pos_next;
    logic [7:0]  left_reg,   left_next;
    logic [15:0] flen_reg,   flen_next;
    logic [7:0]  wtag_reg,   wtag_next;
    logic [7:0]  rtag_reg,   rtag_next;
    logic        done_reg,   done_next;

    // effective state once a first byte restarts the scan
    logic [1:0]  e_phase;
    logic [15:0] e_pos;
    logic [7:0]  e_left;
    logic [15:0] e_flen;
    logic [7:0]  e_wtag;
    logic [7:0]  e_rtag;
    logic [16:0] nxt;
    logic [16:0] val_end;
    logic        short_next;
    logic [7:0]  left_dec;

    always_comb begin
        e_phase = item.first_byte ? tts_pkg::PHASE_TAG : phase_reg;
        e_pos   = item.first_byte ? 16'd0 : pos_reg;
        e_left  = item.first_byte ? 8'd0 : left_reg;
        e_flen  = item.first_byte ? item.frame_length : flen_reg;
        e_wtag  = item.first_byte ? item.wanted_tag : wtag_reg;
        e_rtag  = item.first_byte ? 8'd0 : rtag_reg;
        nxt     = {1'b0, e_pos} + 17'd1;
        val_end = nxt + {9'd0, item.data_byte};
        // fewer than two bytes left after the next record start
        short_next = (nxt + 17'd2) > {1'b0, e_flen};
        left_dec   = (e_left != 8'd0) ? e_left - 8'd1 : 8'd0;
    end

    // one scan step
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        flen_next  = flen_reg;
        wtag_next  = wtag_reg;
        rtag_next  = rtag_reg;
        done_next  = done_reg;
        emit       = 1'b0;
        result.search_status = tts_pkg::ST_ABSENT;
        result.value_offset  = 16'd0;
        result.value_length  = 8'd0;

        if (step && (item.first_byte || !done_reg)) begin
            phase_next = e_phase;
            pos_next   = e_pos;
            left_next  = e_left;
            flen_next  = e_flen;
            wtag_next  = e_wtag;
            rtag_next  = e_rtag;
            done_next  = 1'b0;

            if (item.first_byte && (item.frame_length < 16'd2)) begin
                // short frame
                emit      = 1'b1;
                done_next = 1'b1;
            end else begin
                pos_next = nxt[15:0];
                case (e_phase)
                    tts_pkg::PHASE_TAG: begin
                        rtag_next  = item.data_byte;
                        phase_next = tts_pkg::PHASE_LEN;
                    end
                    tts_pkg::PHASE_LEN: begin
                        if (val_end > {1'b0, e_flen}) begin
                            emit = 1'b1;
                            done_next = 1'b1;
                            result.search_status = tts_pkg::ST_OVERRUN;
                        end else if (e_rtag == e_wtag) begin
                            emit = 1'b1;
                            done_next = 1'b1;
                            result.search_status = tts_pkg::ST_FOUND;
                            result.value_offset  = nxt[15:0];
                            result.value_length  = item.data_byte;
                        end else if (item.data_byte == 8'd0) begin
                            // zero-length record, next tag follows at once
                            phase_next = tts_pkg::PHASE_TAG;
                            if (short_next) begin
                                emit = 1'b1;
                                done_next = 1'b1;
                            end
                        end else begin
                            left_next  = item.data_byte;
                            phase_next = tts_pkg::PHASE_VAL;
                        end
                    end
                    default: begin
                        left_next = left_dec;
                        if (left_dec == 8'd0) begin
                            phase_next = tts_pkg::PHASE_TAG;
                            if (short_next) begin
                                emit = 1'b1;
                                done_next = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tts_pkg::PHASE_TAG;
            pos_reg   <= 16'd0;
            left_reg  <= 8'd0;
            flen_reg  <= 16'd0;
            wtag_reg  <= 8'd0;
            rtag_reg  <= 8'd0;
            done_reg  <= 1'b1;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            flen_reg  <= flen_next;
            wtag_reg  <= wtag_next;
            rtag_reg  <= rtag_next;
            done_reg  <= done_next;
        end
    end

endmodule

### rtl/core/tts_out_stage.sv
// tts_out_stage: result register of the tlv tag scanner
// holds one result transaction until the master side takes it
// depends on tts_pkg
`timescale 1ns / 1ps

module tts_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             emit,
    input  tts_pkg::result_t result,
    output logic             out_free,
    output logic             out_valid,
    input  logic             out_ready,
    output tts_pkg::result_t out_result
);

    logic             valid_reg;
    logic             valid_next;
    tts_pkg::result_t result_reg;

    // free when empty or being drained this cycle
    assign out_free = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = step && emit;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (out_free && step && emit) begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

### rtl/core/tlv_tag_scanner.sv
// tlv_tag_scanner: searches a byte stream of tag-length-value records for a tag
// m_tvalid rises once the byte that decides it has passed the input register, then the result register
// throughput: one byte per cycle while no result waits on m_tready, set by the single registered scan step
// a result waiting on m_tready stalls the input register and then s_tready
// reset: aresetn synchronous, active low; empties both registers, scanner idle
// depends on tts_pkg, tts_in_stage, tts_scan_core, tts_out_stage
`timescale 1ns / 1ps

module tlv_tag_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // data_byte[7:0], frame_length[23:8], wanted_tag[31:24]
    input  logic        s_tuser,   // first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // value_offset[15:0], value_length[23:16]
    output logic [1:0]  m_tuser    // search_status[1:0]
);

    tts_pkg::item_t   in_item;
    tts_pkg::item_t   item;
    tts_pkg::result_t result;
    tts_pkg::result_t out_result;
    logic             item_valid;
    logic             out_free;
    logic             step;
    logic             emit;

    // unpack the slave transaction
    always_comb begin
        in_item.data_byte    = s_tdata[7:0];
        in_item.frame_length = s_tdata[23:8];
        in_item.wanted_tag   = s_tdata[31:24];
        in_item.first_byte   = s_tuser;
    end

    // the held byte is scanned whenever the result register can take its outcome
    assign step = item_valid && out_free;

    tts_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (step),
        .item_valid (item_valid),
        .item       (item)
    );

    tts_scan_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .emit    (emit),
        .result  (result)
    );

    tts_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .emit       (emit),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // pack the master transaction
    assign m_tdata = {out_result.value_length, out_result.value_offset};
    assign m_tuser = out_result.search_status;

endmodule
